// File: design/sm3_hash_stream_unit_macros.svh
// Assertion macros for the SM3 hash stream unit.
// Used by the top level only; no other dependencies.
`ifndef SM3_HASH_STREAM_UNIT_MACROS_SVH
`define SM3_HASH_STREAM_UNIT_MACROS_SVH
`ifndef ASSERT_OFF
// check that cond implies the next-cycle consequence
`define SM3HS_ASSERT_NEXT(label, clk, rst, cond, conseq) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (conseq)) \
      else $error("sm3hs assertion failed");
// check that cond implies the same-cycle consequence
`define SM3HS_ASSERT_NOW(label, clk, rst, cond, conseq) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (conseq)) \
      else $error("sm3hs assertion failed");
`else
`define SM3HS_ASSERT_NEXT(label, clk, rst, cond, conseq)
`define SM3HS_ASSERT_NOW(label, clk, rst, cond, conseq)
`endif
`endif

// File: design/sm3hs_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and helper functions for the SM3 hash stream unit.
// No dependencies.
package sm3hs_pkg;

   typedef struct packed {
      logic [31:0] msg_word;
      logic [2:0]  valid_bytes;
      logic        final_word;
   } req_type;

   typedef struct packed {
      logic [31:0] digest_word;
      logic [2:0]  word_index;
      logic        run_last;
   } rsp_type;

   typedef logic [7:0][31:0] state_vec_type;

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_PAD   = 6'b000010,
      ST_LOAD  = 6'b000100,
      ST_ROUND = 6'b001000,
      ST_FOLD  = 6'b010000,
      ST_OUT   = 6'b100000
   } fsm_type;

   localparam state_vec_type IV = {
      32'hB0FB0E4E, 32'hE38DEE4D, 32'h163138AA, 32'hA96F30BC,
      32'hDA8A0600, 32'h172442D7, 32'h4914B2B9, 32'h7380166F
   };
   localparam logic [31:0] T_LOW    = 32'h79CC4519;
   localparam logic [31:0] T_HIGH   = 32'h7A879D8A;
   localparam logic [31:0] PAD_MARK = 32'h80000000;
   localparam logic [3:0]  LAST_WORD = 4'd15;
   localparam logic [3:0]  LEN_HI_WORD = 4'd14;
   localparam logic [5:0]  LAST_ROUND = 6'd63;
   localparam logic [2:0]  LAST_DIGEST = 3'd7;

   function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] n);
      return (x << n) | (x >> (6'd32 - {1'b0, n}));
   endfunction

   function automatic logic [31:0] perm0(input logic [31:0] x);
      return x ^ rotl(x, 5'd9) ^ rotl(x, 5'd17);
   endfunction

   function automatic logic [31:0] perm1(input logic [31:0] x);
      return x ^ rotl(x, 5'd15) ^ rotl(x, 5'd23);
   endfunction

endpackage

// File: design/sm3_hash_stream_unit.sv
`timescale 1ns / 1ps
// SM3 hash stream unit top level: block memory, padding, compression control.
// Depends on sm3hs_pkg, sm3hs_round and sm3_hash_stream_unit_macros.svh.
//
//   channel | ports            | moves
//   --------+------------------+-------------------------------------------
//   req     | req_valid/stall  | one message word, byte count, final flag
//   rsp     | rsp_valid/stall  | one digest word with index and last flag
//
// A non-final request writes one word to block memory; the sixteenth word of a
// block then starts the load of its sixteen words (registered reads), 64 rounds and a fold.
// The compression runs one round per cycle; no request is taken until after the fold.
// A final request adds padding writes, one or two compressions and eight responses.
// Reset restores the initial vector and clears the byte count.
// req_stall is high whenever the unit is not idle; a stalled response holds.
`include "sm3_hash_stream_unit_macros.svh"
module sm3_hash_stream_unit (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  sm3hs_pkg::req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output sm3hs_pkg::rsp_type rsp_data
);
   import sm3hs_pkg::*;

   fsm_type       state_ff, state_in;
   state_vec_type chain_ff, chain_in;
   state_vec_type work_ff, work_in;
   logic [60:0]   total_ff, total_in;
   logic [3:0]    widx_ff, widx_in;
   logic [4:0]    ld_cnt_ff, ld_cnt_in;
   logic          ld_vld_ff;
   logic [5:0]    round_ff, round_in;
   logic [2:0]    out_idx_ff, out_idx_in;
   logic          fin_ff, fin_in;
   logic          mark_ff, mark_in;
   logic          need_len_ff, need_len_in;
   logic          len_done_ff, len_done_in;

   logic [31:0]   blk_mem [16];
   logic [31:0]   rd_data_ff;
   logic          mem_we;
   logic [31:0]   mem_wdata;

   logic [31:0]   win_ff [16];
   logic          win_shift;
   logic [31:0]   win_new;

   state_vec_type v_nxt;
   logic [31:0]   w_new;
   logic          req_take;
   logic [2:0]    nbytes;
   logic [31:0]   fin_word;
   logic [63:0]   bit_len;

   logic          round_end;
   logic          digest_end;
   logic          unit_clear;

   sm3hs_round u_round (
      .v_cur (work_ff),
      .round (round_ff),
      .w_j   (win_ff[0]),
      .w_j3  (win_ff[3]),
      .w_j4  (win_ff[4]),
      .w_j7  (win_ff[7]),
      .w_j10 (win_ff[10]),
      .w_j13 (win_ff[13]),
      .v_nxt (v_nxt),
      .w_new (w_new)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign rsp_valid = (state_ff == ST_OUT);
   assign rsp_data.digest_word = chain_ff[out_idx_ff];
   assign rsp_data.word_index  = out_idx_ff;
   assign rsp_data.run_last    = (out_idx_ff == LAST_DIGEST);
   assign bit_len = {total_ff, 3'b000};

   // clamp the final byte count; build the closing word, with a pad mark if partial
   always_comb begin
      nbytes = (req_data.valid_bytes > 3'd4) ? 3'd4 : req_data.valid_bytes;
      case (nbytes)
         3'd0:    fin_word = PAD_MARK;
         3'd1:    fin_word = (req_data.msg_word & 32'hFF000000) | (PAD_MARK >> 8);
         3'd2:    fin_word = (req_data.msg_word & 32'hFFFF0000) | (PAD_MARK >> 16);
         3'd3:    fin_word = (req_data.msg_word & 32'hFFFFFF00) | (PAD_MARK >> 24);
         default: fin_word = req_data.msg_word;
      endcase
   end

   // sequence padding, compression and digest output
   always_comb begin
      state_in    = state_ff;
      chain_in    = chain_ff;
      work_in     = work_ff;
      total_in    = total_ff;
      widx_in     = widx_ff;
      ld_cnt_in   = ld_cnt_ff;
      round_in    = round_ff;
      out_idx_in  = out_idx_ff;
      fin_in      = fin_ff;
      mark_in     = mark_ff;
      need_len_in = need_len_ff;
      len_done_in = len_done_ff;
      mem_we      = 1'b0;
      mem_wdata   = req_data.msg_word;
      win_shift   = 1'b0;
      win_new     = rd_data_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               mem_we  = 1'b1;
               widx_in = widx_ff + 4'd1;
               if (req_data.final_word) begin
                  mem_wdata   = fin_word;
                  total_in    = total_ff + {58'd0, nbytes};
                  fin_in      = 1'b1;
                  mark_in     = (nbytes != 3'd4);
                  need_len_in = (nbytes != 3'd4) && (widx_ff < LEN_HI_WORD);
                  len_done_in = 1'b0;
                  state_in    = (widx_ff == LAST_WORD) ? ST_LOAD : ST_PAD;
               end else begin
                  total_in = total_ff + 61'd4;
                  fin_in   = 1'b0;
                  if (widx_ff == LAST_WORD) state_in = ST_LOAD;
               end
               ld_cnt_in = 5'd0;
            end
         end
         ST_PAD: begin
            mem_we    = 1'b1;
            widx_in   = widx_ff + 4'd1;
            mem_wdata = 32'd0;
            if (!mark_ff) begin
               mem_wdata = PAD_MARK;
               mark_in   = 1'b1;
               need_len_in = (widx_ff < LEN_HI_WORD);
            end else if (need_len_ff && widx_ff == LEN_HI_WORD) begin
               mem_wdata = bit_len[63:32];
            end else if (need_len_ff && widx_ff == LAST_WORD) begin
               mem_wdata   = bit_len[31:0];
               len_done_in = 1'b1;
            end
            ld_cnt_in = 5'd0;
            if (widx_ff == LAST_WORD) state_in = ST_LOAD;
         end
         ST_LOAD: begin
            work_in   = chain_ff;
            win_shift = ld_vld_ff;
            if (ld_cnt_ff[4]) begin
               round_in = 6'd0;
               state_in = ST_ROUND;
            end else begin
               ld_cnt_in = ld_cnt_ff + 5'd1;
            end
         end
         ST_ROUND: begin
            work_in   = v_nxt;
            win_shift = 1'b1;
            win_new   = w_new;
            round_in  = round_ff + 6'd1;
            if (round_ff == LAST_ROUND) state_in = ST_FOLD;
         end
         ST_FOLD: begin
            chain_in = chain_ff ^ work_ff;
            if (!fin_ff) begin
               state_in = ST_IDLE;
            end else if (len_done_ff) begin
               out_idx_in = 3'd0;
               state_in   = ST_OUT;
            end else begin
               if (mark_ff) need_len_in = 1'b1;
               state_in = ST_PAD;
            end
         end
         ST_OUT: begin
            if (!rsp_stall) begin
               out_idx_in = out_idx_ff + 3'd1;
               if (out_idx_ff == LAST_DIGEST) begin
                  chain_in = IV;
                  total_in = 61'd0;
                  widx_in  = 4'd0;
                  fin_in   = 1'b0;
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         chain_ff    <= IV;
         total_ff    <= 61'd0;
         widx_ff     <= 4'd0;
         ld_cnt_ff   <= 5'd0;
         ld_vld_ff   <= 1'b0;
         round_ff    <= 6'd0;
         out_idx_ff  <= 3'd0;
         fin_ff      <= 1'b0;
         mark_ff     <= 1'b0;
         need_len_ff <= 1'b0;
         len_done_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         chain_ff    <= chain_in;
         total_ff    <= total_in;
         widx_ff     <= widx_in;
         ld_cnt_ff   <= ld_cnt_in;
         ld_vld_ff   <= (state_ff == ST_LOAD) && !ld_cnt_ff[4];
         round_ff    <= round_in;
         out_idx_ff  <= out_idx_in;
         fin_ff      <= fin_in;
         mark_ff     <= mark_in;
         need_len_ff <= need_len_in;
         len_done_ff <= len_done_in;
      end
   end

   // working variables
   always_ff @(posedge clock) begin
      work_ff <= work_in;
   end

   // block memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) blk_mem[widx_ff] <= mem_wdata;
      rd_data_ff <= blk_mem[ld_cnt_ff[3:0]];
   end

   // expansion window: shift towards slot 0, append at slot 15
   always_ff @(posedge clock) begin
      if (win_shift) begin
         for (int i = 0; i < 15; i++) win_ff[i] <= win_ff[i + 1];
         win_ff[15] <= win_new;
      end
   end

   // conditions watched by the checks below
   assign round_end  = (state_ff == ST_ROUND) && (round_ff == LAST_ROUND);
   assign digest_end = rsp_valid && rsp_data.run_last && !rsp_stall;
   assign unit_clear = (state_ff == ST_IDLE) && (total_ff == 61'd0) && (widx_ff == 4'd0);

   `SM3HS_ASSERT_NEXT(a_last_round_folds, clock, reset, round_end, state_ff == ST_FOLD)
   `SM3HS_ASSERT_NOW(a_round_starts_at_zero, clock, reset, $rose(state_ff == ST_ROUND), round_ff == 6'd0)
   `SM3HS_ASSERT_NEXT(a_digest_end_clears, clock, reset, digest_end, unit_clear)

endmodule

// File: design/sm3hs_round.sv
`timescale 1ns / 1ps
// One SM3 compression round plus one message expansion step.
// Depends on sm3hs_pkg.
module sm3hs_round (
   input  sm3hs_pkg::state_vec_type v_cur,
   input  logic [5:0]               round,
   input  logic [31:0]              w_j,
   input  logic [31:0]              w_j3,
   input  logic [31:0]              w_j4,
   input  logic [31:0]              w_j7,
   input  logic [31:0]              w_j10,
   input  logic [31:0]              w_j13,
   output sm3hs_pkg::state_vec_type v_nxt,
   output logic [31:0]              w_new
);
   import sm3hs_pkg::*;

   logic        early;
   logic [31:0] tj, a12, ss1, ss2, ff, gg, tt1, tt2;

   // compute round terms
   always_comb begin
      early = (round[5:4] == 2'b00);
      tj    = early ? T_LOW : T_HIGH;
      a12   = rotl(v_cur[0], 5'd12);
      ss1   = rotl(a12 + v_cur[4] + rotl(tj, round[4:0]), 5'd7);
      ss2   = ss1 ^ a12;
      if (early) begin
         ff = v_cur[0] ^ v_cur[1] ^ v_cur[2];
         gg = v_cur[4] ^ v_cur[5] ^ v_cur[6];
      end else begin
         ff = (v_cur[0] & v_cur[1]) | (v_cur[0] & v_cur[2]) | (v_cur[1] & v_cur[2]);
         gg = (v_cur[4] & v_cur[5]) | (~v_cur[4] & v_cur[6]);
      end
      tt1 = ff + v_cur[3] + ss2 + (w_j ^ w_j4);
      tt2 = gg + v_cur[7] + ss1 + w_j;
   end

   // advance working variables
   always_comb begin
      v_nxt[0] = tt1;
      v_nxt[1] = v_cur[0];
      v_nxt[2] = rotl(v_cur[1], 5'd9);
      v_nxt[3] = v_cur[2];
      v_nxt[4] = perm0(tt2);
      v_nxt[5] = v_cur[4];
      v_nxt[6] = rotl(v_cur[5], 5'd19);
      v_nxt[7] = v_cur[6];
   end

   // expand the next message word
   assign w_new = perm1(w_j ^ w_j7 ^ rotl(w_j13, 5'd15)) ^ rotl(w_j3, 5'd7) ^ w_j10;

endmodule
